[hdl/prwl_pkg.sv]
`default_nettype none

package prwl_pkg;

    // Request operation codes.
    typedef enum logic [2:0] {
        OP_READ      = 3'd0,
        OP_WRITE     = 3'd1,
        OP_TRY_READ  = 3'd2,
        OP_TRY_WRITE = 3'd3,
        OP_UNLOCK    = 3'd4,
        OP_CANCEL    = 3'd5
    } op_t;

    // Result status codes.
    typedef enum logic [2:0] {
        ST_GRANTED     = 3'd0,
        ST_QUEUED      = 3'd1,
        ST_BUSY        = 3'd2,
        ST_NOT_HELD    = 3'd3,
        ST_CANCELLED   = 3'd4,
        ST_NOT_WAITING = 3'd5,
        ST_QUEUE_FULL  = 3'd6,
        ST_WOKEN       = 3'd7
    } status_t;

    // Sequencer states.
    typedef enum logic [3:0] {
        S_IDLE,
        S_DECIDE,
        S_ISCAN,
        S_IRD,
        S_ISHIFT,
        S_IWR,
        S_CSCAN,
        S_CSHIFT,
        S_WGET,
        S_WNEXT,
        S_WCHK
    } state_t;

    // One waiter as stored in the queue memory.
    typedef struct packed {
        logic [7:0] id;
        logic [7:0] prio;
        logic       writer;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    // Most waiters that one unlock may wake.
    localparam logic [4:0] MAX_WAKES = 5'd16;

endpackage

`default_nettype wire

[hdl/priority_fair_rwlock_manager.sv]
// Channel   Direction  Handshake                    Fields
// request   in         start & !busy                operation, requester_id, requester_priority
// result    out        strobe, one cycle, no stall  status, target_id, target_priority,
//                                                   woken_is_writer, last
//
// An item that needs no queue walk is answered from S_DECIDE; its result shows while
// the block is idle again and can already take the next item. Queue inserts scan for
// the place and move the entries behind it, cancels search for the waiter and close
// the gap, and an unlock wakes a writer or a run of readers, all through the single
// queue memory port pair. Reset is asynchronous and clears the lock and the queue
// pointers; the queue memory needs no clearing. Results cannot be stalled.
`default_nettype none

module priority_fair_rwlock_manager #(
    parameter int QUEUE_DEPTH = 16,
    parameter int MAX_READERS = 255
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       start,
    output logic            busy,
    input  wire logic [2:0] operation,
    input  wire logic [7:0] requester_id,
    input  wire logic [7:0] requester_priority,
    output logic            strobe,
    output logic      [2:0] status,
    output logic      [7:0] target_id,
    output logic      [7:0] target_priority,
    output logic            woken_is_writer,
    output logic            last
);

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);
    localparam logic signed [8:0] MAXR_C = 9'(MAX_READERS);

    prwl_pkg::state_t state_reg, state_next;
    logic signed [8:0] holder_reg, holder_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [AW-1:0]     head_reg, head_next;
    logic [CW-1:0]     idx_reg, idx_next;
    logic [CW-1:0]     j_reg, j_next;
    logic [4:0]        wakes_reg, wakes_next;
    prwl_pkg::op_t     op_reg, op_next;
    logic [7:0]        id_reg, id_next;
    logic [7:0]        pr_reg, pr_next;
    prwl_pkg::entry_t  e_reg, e_next;

    logic              strobe_reg, strobe_next;
    prwl_pkg::status_t status_reg, status_next;
    logic [7:0]        tid_reg, tid_next;
    logic [7:0]        tpr_reg, tpr_next;
    logic              wr_reg, wr_next;
    logic              last_reg, last_next;

    logic                         ram_we;
    logic [AW-1:0]                ram_waddr;
    prwl_pkg::entry_t             ram_wdata;
    logic [AW-1:0]                ram_raddr;
    logic [prwl_pkg::ENTRY_W-1:0] ram_rdata_raw;
    prwl_pkg::entry_t             rd;

    logic              blocked;
    logic signed [8:0] holder_dec;

    // Queue offset from the head to a physical address, wrapping once.
    function automatic logic [AW-1:0] phys(input logic [AW-1:0] head,
                                           input logic [CW-1:0] off);
        logic [CW:0] s;
        s = (CW+1)'(head) + (CW+1)'(off);
        if (s >= (CW+1)'(QUEUE_DEPTH))
        begin
            s = s - (CW+1)'(QUEUE_DEPTH);
        end
        return s[AW-1:0];
    endfunction

    prwl_ram #(
        .WIDTH (prwl_pkg::ENTRY_W),
        .DEPTH (QUEUE_DEPTH),
        .AW    (AW)
    ) u_queue (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata_raw)
    );

    assign rd = prwl_pkg::entry_t'(ram_rdata_raw);

    // State and payload registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= prwl_pkg::S_IDLE;
            holder_reg <= '0;
            count_reg  <= '0;
            head_reg   <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            holder_reg <= holder_next;
            count_reg  <= count_next;
            head_reg   <= head_next;
            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        j_reg      <= j_next;
        wakes_reg  <= wakes_next;
        op_reg     <= op_next;
        id_reg     <= id_next;
        pr_reg     <= pr_next;
        e_reg      <= e_next;
        status_reg <= status_next;
        tid_reg    <= tid_next;
        tpr_reg    <= tpr_next;
        wr_reg     <= wr_next;
        last_reg   <= last_next;
    end

    // A reader waits behind a writer holder or a queue head writer at least as urgent.
    assign blocked = holder_reg[8] ||
                     ((count_reg != '0) && rd.writer && (rd.prio <= pr_reg));
    assign holder_dec = holder_reg[8] ? 9'sd0 : holder_reg - 9'sd1;

    // Sequencer: next state, queue memory access and result generation.
    always_comb
    begin
        state_next  = state_reg;
        holder_next = holder_reg;
        count_next  = count_reg;
        head_next   = head_reg;
        idx_next    = idx_reg;
        j_next      = j_reg;
        wakes_next  = wakes_reg;
        op_next     = op_reg;
        id_next     = id_reg;
        pr_next     = pr_reg;
        e_next      = e_reg;
        strobe_next = 1'b0;
        status_next = status_reg;
        tid_next    = tid_reg;
        tpr_next    = tpr_reg;
        wr_next     = wr_reg;
        last_next   = last_reg;
        ram_we      = 1'b0;
        ram_waddr   = head_reg;
        ram_wdata   = e_reg;
        ram_raddr   = head_reg;

        unique case (state_reg)
            prwl_pkg::S_IDLE:
            begin
                if (start)
                begin
                    op_next    = prwl_pkg::op_t'(operation);
                    id_next    = requester_id;
                    pr_next    = requester_priority;
                    state_next = prwl_pkg::S_DECIDE;
                end
            end

            prwl_pkg::S_DECIDE:
            begin
                // Reply fields common to all decisions here.
                tid_next    = id_reg;
                tpr_next    = pr_reg;
                wr_next     = 1'b0;
                last_next   = 1'b1;
                status_next = prwl_pkg::ST_BUSY;
                state_next  = prwl_pkg::S_IDLE;
                strobe_next = 1'b1;
                idx_next    = '0;
                unique case (op_reg)
                    prwl_pkg::OP_READ,
                    prwl_pkg::OP_TRY_READ:
                    begin
                        if (blocked)
                        begin
                            if (op_reg == prwl_pkg::OP_READ)
                            begin
                                if (count_reg == DEPTH_C)
                                begin
                                    status_next = prwl_pkg::ST_QUEUE_FULL;
                                end
                                else
                                begin
                                    strobe_next = 1'b0;
                                    state_next  = (count_reg == '0) ?
                                                  prwl_pkg::S_IWR : prwl_pkg::S_ISCAN;
                                end
                            end
                        end
                        else if (holder_reg < MAXR_C)
                        begin
                            holder_next = holder_reg + 9'sd1;
                            status_next = prwl_pkg::ST_GRANTED;
                        end
                    end
                    prwl_pkg::OP_WRITE,
                    prwl_pkg::OP_TRY_WRITE:
                    begin
                        if (holder_reg != 9'sd0)
                        begin
                            if (op_reg == prwl_pkg::OP_WRITE)
                            begin
                                if (count_reg == DEPTH_C)
                                begin
                                    status_next = prwl_pkg::ST_QUEUE_FULL;
                                end
                                else
                                begin
                                    strobe_next = 1'b0;
                                    state_next  = (count_reg == '0) ?
                                                  prwl_pkg::S_IWR : prwl_pkg::S_ISCAN;
                                end
                            end
                        end
                        else
                        begin
                            holder_next = -9'sd1;
                            status_next = prwl_pkg::ST_GRANTED;
                        end
                    end
                    prwl_pkg::OP_UNLOCK:
                    begin
                        if (holder_reg == 9'sd0)
                        begin
                            status_next = prwl_pkg::ST_NOT_HELD;
                        end
                        else
                        begin
                            status_next = prwl_pkg::ST_GRANTED;
                            holder_next = holder_dec;
                            if ((holder_dec == 9'sd0) && (count_reg != '0))
                            begin
                                last_next  = 1'b0;
                                state_next = prwl_pkg::S_WGET;
                            end
                        end
                    end
                    prwl_pkg::OP_CANCEL:
                    begin
                        if (count_reg == '0)
                        begin
                            status_next = prwl_pkg::ST_NOT_WAITING;
                        end
                        else
                        begin
                            strobe_next = 1'b0;
                            state_next  = prwl_pkg::S_CSCAN;
                        end
                    end
                    default:
                    begin
                        status_next = prwl_pkg::ST_BUSY;
                    end
                endcase
            end

            // Find the first entry less urgent than the new waiter.
            prwl_pkg::S_ISCAN:
            begin
                ram_raddr = phys(head_reg, idx_reg + CW'(1));
                if (rd.prio > pr_reg)
                begin
                    state_next = prwl_pkg::S_IRD;
                end
                else if ((CW+1)'(idx_reg) + (CW+1)'(1) < (CW+1)'(count_reg))
                begin
                    idx_next = idx_reg + CW'(1);
                end
                else
                begin
                    idx_next   = count_reg;
                    state_next = prwl_pkg::S_IRD;
                end
            end

            prwl_pkg::S_IRD:
            begin
                if (idx_reg < count_reg)
                begin
                    j_next     = count_reg - CW'(1);
                    ram_raddr  = phys(head_reg, count_reg - CW'(1));
                    state_next = prwl_pkg::S_ISHIFT;
                end
                else
                begin
                    state_next = prwl_pkg::S_IWR;
                end
            end

            // Move the tail up by one, last entry first.
            prwl_pkg::S_ISHIFT:
            begin
                ram_we    = 1'b1;
                ram_waddr = phys(head_reg, j_reg + CW'(1));
                ram_wdata = rd;
                if (j_reg > idx_reg)
                begin
                    ram_raddr = phys(head_reg, j_reg - CW'(1));
                    j_next    = j_reg - CW'(1);
                end
                else
                begin
                    state_next = prwl_pkg::S_IWR;
                end
            end

            prwl_pkg::S_IWR:
            begin
                ram_we           = 1'b1;
                ram_waddr        = phys(head_reg, idx_reg);
                ram_wdata.id     = id_reg;
                ram_wdata.prio   = pr_reg;
                ram_wdata.writer = (op_reg == prwl_pkg::OP_WRITE);
                count_next       = count_reg + CW'(1);
                strobe_next      = 1'b1;
                status_next      = prwl_pkg::ST_QUEUED;
                tid_next         = id_reg;
                tpr_next         = pr_reg;
                wr_next          = 1'b0;
                last_next        = 1'b1;
                state_next       = prwl_pkg::S_IDLE;
            end

            // Search for the first waiter with the requester's id.
            prwl_pkg::S_CSCAN:
            begin
                ram_raddr = phys(head_reg, idx_reg + CW'(1));
                if (rd.id == id_reg)
                begin
                    state_next = prwl_pkg::S_CSHIFT;
                end
                else if ((CW+1)'(idx_reg) + (CW+1)'(1) < (CW+1)'(count_reg))
                begin
                    idx_next = idx_reg + CW'(1);
                end
                else
                begin
                    strobe_next = 1'b1;
                    status_next = prwl_pkg::ST_NOT_WAITING;
                    tid_next    = id_reg;
                    tpr_next    = pr_reg;
                    wr_next     = 1'b0;
                    last_next   = 1'b1;
                    state_next  = prwl_pkg::S_IDLE;
                end
            end

            // Close the gap left by the cancelled waiter.
            prwl_pkg::S_CSHIFT:
            begin
                if ((CW+1)'(idx_reg) + (CW+1)'(1) < (CW+1)'(count_reg))
                begin
                    ram_we    = 1'b1;
                    ram_waddr = phys(head_reg, idx_reg);
                    ram_wdata = rd;
                    ram_raddr = phys(head_reg, idx_reg + CW'(2));
                    idx_next  = idx_reg + CW'(1);
                end
                else
                begin
                    count_next  = count_reg - CW'(1);
                    strobe_next = 1'b1;
                    status_next = prwl_pkg::ST_CANCELLED;
                    tid_next    = id_reg;
                    tpr_next    = pr_reg;
                    wr_next     = 1'b0;
                    last_next   = 1'b1;
                    state_next  = prwl_pkg::S_IDLE;
                end
            end

            // Pop the queue head after the last holder left.
            prwl_pkg::S_WGET:
            begin
                e_next     = rd;
                head_next  = phys(head_reg, CW'(1));
                count_next = count_reg - CW'(1);
                if (rd.writer)
                begin
                    holder_next = -9'sd1;
                    strobe_next = 1'b1;
                    status_next = prwl_pkg::ST_WOKEN;
                    tid_next    = rd.id;
                    tpr_next    = rd.prio;
                    wr_next     = 1'b1;
                    last_next   = 1'b1;
                    state_next  = prwl_pkg::S_IDLE;
                end
                else
                begin
                    holder_next = 9'sd1;
                    wakes_next  = 5'd1;
                    state_next  = prwl_pkg::S_WNEXT;
                end
            end

            // A reader run may go on; the read of the new head is issued here.
            prwl_pkg::S_WNEXT:
            begin
                if ((count_reg != '0) && (holder_reg < MAXR_C) &&
                    (wakes_reg < prwl_pkg::MAX_WAKES))
                begin
                    state_next = prwl_pkg::S_WCHK;
                end
                else
                begin
                    strobe_next = 1'b1;
                    status_next = prwl_pkg::ST_WOKEN;
                    tid_next    = e_reg.id;
                    tpr_next    = e_reg.prio;
                    wr_next     = 1'b0;
                    last_next   = 1'b1;
                    state_next  = prwl_pkg::S_IDLE;
                end
            end

            // Emit the pending reader; last only if the next head is a writer.
            prwl_pkg::S_WCHK:
            begin
                strobe_next = 1'b1;
                status_next = prwl_pkg::ST_WOKEN;
                tid_next    = e_reg.id;
                tpr_next    = e_reg.prio;
                wr_next     = 1'b0;
                if (!rd.writer)
                begin
                    last_next   = 1'b0;
                    e_next      = rd;
                    head_next   = phys(head_reg, CW'(1));
                    count_next  = count_reg - CW'(1);
                    holder_next = holder_reg + 9'sd1;
                    wakes_next  = wakes_reg + 5'd1;
                    state_next  = prwl_pkg::S_WNEXT;
                end
                else
                begin
                    last_next  = 1'b1;
                    state_next = prwl_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = prwl_pkg::S_IDLE;
            end
        endcase
    end

    assign busy            = (state_reg != prwl_pkg::S_IDLE);
    assign strobe          = strobe_reg;
    assign status          = status_reg;
    assign target_id       = tid_reg;
    assign target_priority = tpr_reg;
    assign woken_is_writer = wr_reg;
    assign last            = last_reg;

endmodule

`default_nettype wire

[hdl/prwl_ram.sv]
`default_nettype none

module prwl_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Single write port, registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire
